// ----- rtl/rau_pkg.sv -----
`default_nettype none
package rau_pkg;
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;
    localparam int RESULT_WIDTH = 33;

    typedef struct packed {
        logic load;
        logic start;
    } rau_cmd_t;

    typedef struct packed {
        logic prod_done;
        logic both_zero;
        logic div_done;
        logic rem_zero;
    } rau_status_t;
endpackage
`default_nettype wire

// ----- rtl/rau_divider.sv -----
`default_nettype none
module rau_divider #(
    parameter int WIDTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ----- rtl/rau_datapath.sv -----
`default_nettype none
module rau_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [1:0]               command,
    input  wire logic [OPERAND_WIDTH-1:0] left_num,
    input  wire logic [OPERAND_WIDTH-1:0] left_den,
    input  wire logic [OPERAND_WIDTH-1:0] right_num,
    input  wire logic [OPERAND_WIDTH-1:0] right_den,
    input  wire logic                     ld_in,
    input  wire logic                     prod_go,
    input  wire logic                     sum_go,
    input  wire logic                     div_go,
    input  wire logic                     div_ratio,
    input  wire logic                     den_sel,
    input  wire logic                     euclid_step,
    input  wire logic                     ratio_num,
    input  wire logic                     ratio_den,
    output logic                          both_zero,
    output logic                          div_done,
    output logic                          rem_zero,
    output logic [rau_pkg::RESULT_WIDTH-1:0] res_num,
    output logic [rau_pkg::RESULT_WIDTH-1:0] res_den
);
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int SW = MW + 1;
    localparam int RW = rau_pkg::RESULT_WIDTH;

    logic [1:0]            cmd_reg;
    logic [OPERAND_WIDTH:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic [OPERAND_WIDTH:0] ln_mag, ld_mag, rn_mag, rd_mag;
    logic [MW-1:0]         pa_reg, pb_reg, pd_reg;
    logic                  pa_neg_reg, pb_neg_reg, pd_neg_reg;
    logic [SW-1:0]         n_mag_reg, d_mag_reg, x_reg, y_reg;
    logic                  n_neg_reg, d_neg_reg, par_reg;
    logic [RW-1:0]         rn_reg_o, rd_reg_o;
    logic [SW-1:0]         div_a, div_b, quo, rem;
    logic [SW:0]           ssum;
    logic                  pb_neg_eff;
    logic                  g_neg;
    logic [SW-1:0]         qmag;
    logic [RW-1:0]         qfield;

    function automatic logic [OPERAND_WIDTH:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
        logic [OPERAND_WIDTH:0] e;
        e = {v[OPERAND_WIDTH-1], v};
        return e[OPERAND_WIDTH] ? -e : e;
    endfunction

    rau_divider #(.WIDTH(SW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    assign ln_mag = mag_of(left_num);
    assign ld_mag = mag_of(left_den);
    assign rn_mag = mag_of(right_num);
    assign rd_mag = mag_of(right_den);

    assign div_a = div_ratio ? (den_sel ? d_mag_reg : n_mag_reg) : x_reg;
    assign div_b = div_ratio ? x_reg : y_reg;
    assign pb_neg_eff = pb_neg_reg ^ (cmd_reg == rau_pkg::CMD_SUB);
    assign g_neg = par_reg ? d_neg_reg : n_neg_reg;

    always_comb begin
        if (pa_neg_reg == pb_neg_eff) begin
            ssum = {2'b0, pa_reg} + {2'b0, pb_reg};
        end else if (pa_reg >= pb_reg) begin
            ssum = {2'b0, pa_reg} - {2'b0, pb_reg};
        end else begin
            ssum = {2'b0, pb_reg} - {2'b0, pa_reg};
        end
    end

    always_comb begin
        qmag = quo;
        if (ratio_num && (qmag != '0) && (n_neg_reg != g_neg)) begin
            qfield = -RW'(qmag);
        end else if (ratio_den && (qmag != '0) && (d_neg_reg != g_neg)) begin
            qfield = -RW'(qmag);
        end else begin
            qfield = RW'(qmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_in) begin
            cmd_reg <= command;
            ln_reg  <= {left_num[OPERAND_WIDTH-1], ln_mag[OPERAND_WIDTH-1:0]};
            ld_reg  <= {left_den[OPERAND_WIDTH-1], ld_mag[OPERAND_WIDTH-1:0]};
            rn_reg  <= {right_num[OPERAND_WIDTH-1], rn_mag[OPERAND_WIDTH-1:0]};
            rd_reg  <= {right_den[OPERAND_WIDTH-1], rd_mag[OPERAND_WIDTH-1:0]};
        end
        if (prod_go) begin
            pa_reg <= MW'(ln_reg[OPERAND_WIDTH-1:0])
                    * MW'(cmd_reg == rau_pkg::CMD_MUL
                        ? rn_reg[OPERAND_WIDTH-1:0] : rd_reg[OPERAND_WIDTH-1:0]);
            pa_neg_reg <= ln_reg[OPERAND_WIDTH] ^ (cmd_reg == rau_pkg::CMD_MUL
                          ? rn_reg[OPERAND_WIDTH] : rd_reg[OPERAND_WIDTH]);
            pb_reg <= MW'(ld_reg[OPERAND_WIDTH-1:0]) * MW'(rn_reg[OPERAND_WIDTH-1:0]);
            pb_neg_reg <= ld_reg[OPERAND_WIDTH] ^ rn_reg[OPERAND_WIDTH];
            pd_reg <= MW'(ld_reg[OPERAND_WIDTH-1:0]) * MW'(rd_reg[OPERAND_WIDTH-1:0]);
            pd_neg_reg <= ld_reg[OPERAND_WIDTH] ^ rd_reg[OPERAND_WIDTH];
        end
        if (sum_go) begin
            if (cmd_reg == rau_pkg::CMD_ADD || cmd_reg == rau_pkg::CMD_SUB) begin
                n_mag_reg <= ssum[SW-1:0];
                n_neg_reg <= (ssum != '0) && ((pa_neg_reg == pb_neg_eff || pa_reg >= pb_reg)
                             ? pa_neg_reg : pb_neg_eff);
            end else if (cmd_reg == rau_pkg::CMD_MUL) begin
                n_mag_reg <= SW'(pa_reg);
                n_neg_reg <= (pa_reg != '0) && pa_neg_reg;
            end else begin
                n_mag_reg <= SW'(pa_reg);
                n_neg_reg <= (pa_reg != '0) && pa_neg_reg;
            end
            if (cmd_reg == rau_pkg::CMD_DIV) begin
                d_mag_reg <= SW'(pb_reg);
                d_neg_reg <= (pb_reg != '0) && pb_neg_reg;
                y_reg     <= SW'(pb_reg);
            end else begin
                d_mag_reg <= SW'(pd_reg);
                d_neg_reg <= (pd_reg != '0) && pd_neg_reg;
                y_reg     <= SW'(pd_reg);
            end
            x_reg   <= (cmd_reg == rau_pkg::CMD_ADD || cmd_reg == rau_pkg::CMD_SUB)
                       ? ssum[SW-1:0] : SW'(pa_reg);
            par_reg <= 1'b0;
        end
        if (euclid_step) begin
            x_reg   <= y_reg;
            y_reg   <= rem;
            par_reg <= ~par_reg;
        end
        if (ratio_num) begin
            rn_reg_o <= qfield;
        end
        if (ratio_den) begin
            rd_reg_o <= qfield;
        end
    end

    assign both_zero = (n_mag_reg == '0) && (d_mag_reg == '0);
    assign rem_zero  = (y_reg == '0);
    assign res_num   = rn_reg_o;
    assign res_den   = rd_reg_o;
endmodule
`default_nettype wire

// ----- rtl/rau_controller.sv -----
`default_nettype none
module rau_controller (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire logic out_fire,
    input  wire logic both_zero,
    input  wire logic div_done,
    input  wire logic rem_zero,
    output logic      in_ready,
    output logic      out_valid,
    output logic      err,
    output logic      prod_go,
    output logic      sum_go,
    output logic      div_go,
    output logic      div_ratio,
    output logic      den_sel,
    output logic      euclid_step,
    output logic      ratio_num,
    output logic      ratio_den
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PROD = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_EWT  = 4'd4;
    localparam logic [3:0] S_NGO  = 4'd5;
    localparam logic [3:0] S_NWT  = 4'd6;
    localparam logic [3:0] S_DGO  = 4'd7;
    localparam logic [3:0] S_DWT  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       err_reg, err_next;

    always_comb begin
        state_next  = state_reg;
        err_next    = err_reg;
        prod_go     = 1'b0;
        sum_go      = 1'b0;
        div_go      = 1'b0;
        div_ratio   = 1'b0;
        den_sel     = 1'b0;
        euclid_step = 1'b0;
        ratio_num   = 1'b0;
        ratio_den   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                prod_go    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                sum_go     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (both_zero) begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end else if (rem_zero) begin
                    err_next   = 1'b0;
                    state_next = S_NGO;
                end else begin
                    err_next   = 1'b0;
                    div_go     = 1'b1;
                    state_next = S_EWT;
                end
            end
            S_EWT: begin
                if (div_done) begin
                    euclid_step = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_NGO: begin
                div_ratio  = 1'b1;
                div_go     = 1'b1;
                state_next = S_NWT;
            end
            S_NWT: begin
                div_ratio = 1'b1;
                if (div_done) begin
                    ratio_num  = 1'b1;
                    state_next = S_DGO;
                end
            end
            S_DGO: begin
                div_ratio  = 1'b1;
                den_sel    = 1'b1;
                div_go     = 1'b1;
                state_next = S_DWT;
            end
            S_DWT: begin
                div_ratio = 1'b1;
                den_sel   = 1'b1;
                if (div_done) begin
                    ratio_den  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign err       = err_reg;
endmodule
`default_nettype wire

// ----- rtl/rational_arith_unit_core.sv -----
`default_nettype none
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and reduces the result by Euclid's algorithm with truncating
// remainder, so the denominator may come out negative. One word is handled
// at a time; every remainder step and both final divisions run through one
// shared bit-serial divider of 2 * OPERAND_WIDTH + 1 bits. When both raw
// parts are zero the pair (0, 0) is returned with m_zero_zero_error set.
module rational_arith_unit_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_command,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_left_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_left_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_right_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_right_den,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [32:0]            m_result_num,
    output logic signed [32:0]            m_result_den,
    output logic                          m_zero_zero_error
);
    logic in_fire, out_fire, both_zero, div_done, rem_zero, err;
    logic prod_go, sum_go, div_go, div_ratio, den_sel, euclid_step, ratio_num, ratio_den;
    logic [32:0] res_num, res_den;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    rau_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .both_zero(both_zero), .div_done(div_done), .rem_zero(rem_zero),
        .in_ready(s_ready), .out_valid(m_valid), .err(err),
        .prod_go(prod_go), .sum_go(sum_go), .div_go(div_go), .div_ratio(div_ratio),
        .den_sel(den_sel),
        .euclid_step(euclid_step), .ratio_num(ratio_num), .ratio_den(ratio_den)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .command(s_command),
        .left_num(s_left_num), .left_den(s_left_den),
        .right_num(s_right_num), .right_den(s_right_den),
        .ld_in(in_fire), .prod_go(prod_go), .sum_go(sum_go), .div_go(div_go),
        .div_ratio(div_ratio), .den_sel(den_sel), .euclid_step(euclid_step),
        .ratio_num(ratio_num), .ratio_den(ratio_den),
        .both_zero(both_zero), .div_done(div_done), .rem_zero(rem_zero),
        .res_num(res_num), .res_den(res_den)
    );

    assign m_result_num      = err ? '0 : res_num;
    assign m_result_den      = err ? '0 : res_den;
    assign m_zero_zero_error = err;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and output open together");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready) else $error("accepted a second word while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_num))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
